// ----- rtl/core/dpp_pkg.sv -----
// Shared types, constants and tables for the depth pixel back-projection block.
package dpp_pkg;

  // Image and depth format constants
  localparam int MAX_DIM         = 4096;
  localparam int DEPTH_FRAC_BITS = 16;

  // Register reset values: 0.1 m and 100 m in the depth fixed-point format
  localparam logic [31:0] DEPTH_MIN_RST =
    32'(((64'd1 << DEPTH_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] DEPTH_MAX_RST = 32'(64'd100 << DEPTH_FRAC_BITS);

  // Configuration register indexes
  localparam logic [2:0] CFG_PIXEL_STRIDE  = 3'd0;
  localparam logic [2:0] CFG_DEPTH_MINIMUM = 3'd1;
  localparam logic [2:0] CFG_DEPTH_MAXIMUM = 3'd2;
  localparam logic [2:0] CFG_CENTER_COL    = 3'd3;
  localparam logic [2:0] CFG_CENTER_ROW    = 3'd4;
  localparam logic [2:0] CFG_RECIP_FOCAL_X = 3'd5;
  localparam logic [2:0] CFG_RECIP_FOCAL_Y = 3'd6;

  // Stride reciprocal: ceil(2^STR_SHIFT / s), exact quotient for 12-bit pixels
  localparam int          STR_SHIFT = 18;
  localparam int          STR_ONE   = 2 ** STR_SHIFT;
  localparam int          STR_RW    = STR_SHIFT + 1;
  localparam logic [STR_RW-1:0] STRIDE_RECIP [32] = '{
    STR_RW'(STR_ONE),
    STR_RW'(STR_ONE),
    STR_RW'((STR_ONE + 1) / 2),
    STR_RW'((STR_ONE + 2) / 3),
    STR_RW'((STR_ONE + 3) / 4),
    STR_RW'((STR_ONE + 4) / 5),
    STR_RW'((STR_ONE + 5) / 6),
    STR_RW'((STR_ONE + 6) / 7),
    STR_RW'((STR_ONE + 7) / 8),
    STR_RW'((STR_ONE + 8) / 9),
    STR_RW'((STR_ONE + 9) / 10),
    STR_RW'((STR_ONE + 10) / 11),
    STR_RW'((STR_ONE + 11) / 12),
    STR_RW'((STR_ONE + 12) / 13),
    STR_RW'((STR_ONE + 13) / 14),
    STR_RW'((STR_ONE + 14) / 15),
    STR_RW'((STR_ONE + 15) / 16),
    STR_RW'((STR_ONE + 16) / 17),
    STR_RW'((STR_ONE + 17) / 18),
    STR_RW'((STR_ONE + 18) / 19),
    STR_RW'((STR_ONE + 19) / 20),
    STR_RW'((STR_ONE + 20) / 21),
    STR_RW'((STR_ONE + 21) / 22),
    STR_RW'((STR_ONE + 22) / 23),
    STR_RW'((STR_ONE + 23) / 24),
    STR_RW'((STR_ONE + 24) / 25),
    STR_RW'((STR_ONE + 25) / 26),
    STR_RW'((STR_ONE + 26) / 27),
    STR_RW'((STR_ONE + 27) / 28),
    STR_RW'((STR_ONE + 28) / 29),
    STR_RW'((STR_ONE + 29) / 30),
    STR_RW'((STR_ONE + 30) / 31)
  };

  // Input item
  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [31:0] depth_value;
    logic        depth_finite;
    logic        frame_last;
  } dpp_in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic               point_valid;
    logic               frame_end;
  } dpp_out_t;

  // Per-stage load enables shared by the datapath modules
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } dpp_stage_ld_t;

endpackage

// ----- rtl/core/dpp_axis.sv -----
// One projection axis: (pix*256 - center) * depth * recip, rounded and saturated.
module dpp_axis (
  input  logic                  clk,
  input  dpp_pkg::dpp_stage_ld_t ld,
  input  logic [11:0]           pix,
  input  logic [19:0]           center,
  input  logic [31:0]           depth_s1,
  input  logic [24:0]           recip,
  output logic signed [31:0]    coord
);
  import dpp_pkg::*;

  logic [19:0] pos;
  logic        neg;
  logic [19:0] diff;

  logic [19:0] s1_diff_r;
  logic        s1_neg_r;
  logic [51:0] s2_a_r;
  logic        s2_neg_r;
  logic [44:0] s3_ph_r;
  logic [57:0] s3_pl_r;
  logic        s3_neg_r;
  logic [45:0] s4_mag_r;
  logic        s4_neg_r;

  // Stage 1: signed offset from the principal point, as sign and magnitude
  always_comb begin
    pos  = {pix, 8'd0};
    neg  = pos < center;
    diff = neg ? (center - pos) : (pos - center);
  end

  // Stage pipeline; a stage loads when it is empty or when its item moves on
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      s1_diff_r <= diff;
      s1_neg_r  <= neg;
    end
    if (ld.s2) begin
      s2_a_r   <= 52'(s1_diff_r) * 52'(depth_s1);
      s2_neg_r <= s1_neg_r;
    end
    if (ld.s3) begin
      // high and low halves times recip; rounding half folded into the low part
      s3_ph_r  <= 45'(s2_a_r[51:32]) * 45'(recip);
      s3_pl_r  <= 58'(s2_a_r[31:0]) * 58'(recip) + 58'h0_8000_0000;
      s3_neg_r <= s2_neg_r;
    end
    if (ld.s4) begin
      s4_mag_r <= 46'(s3_ph_r) + 46'(s3_pl_r[57:32]);
      s4_neg_r <= s3_neg_r;
    end
  end

  // Apply sign and saturate to signed Q16.16
  always_comb begin
    if (s4_mag_r[45:31] != '0) begin
      coord = s4_neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (s4_neg_r) begin
      coord = -$signed(s4_mag_r[31:0]);
    end else begin
      coord = $signed(s4_mag_r[31:0]);
    end
  end

endmodule

// ----- rtl/core/depth_pixel_to_point.sv -----
// Top level: depth pixel to 3D point back-projection pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one depth pixel per
//   item. Result channel (out_valid / out_stall / out_data) carries at most
//   one point per item: a kept pixel gives a point with point_valid set, a
//   dropped pixel with frame_last gives a bare frame marker, any other
//   dropped pixel gives nothing.
//   Configuration (cfg_we / cfg_index / cfg_data) writes one register per
//   cycle; write only while no item is in flight.
// Timing:
//   An item passes from input accept to out_valid through four datapath stages
//   (offset and filters, depth product, reciprocal products, rounding sum)
//   and the output register. Throughput is one item per clock when out_stall
//   is low; the 20x32 depth and 32x25 reciprocal products per axis set the stage depth.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and loads register
//   defaults: stride 1, range 0.1 m to 100 m, focal reciprocals 0 (all
//   pixels dropped until both are written).
// Stall:
//   While out_stall holds, the result stays put and empty stages still fill;
//   in_stall rises only once the first stage holds an item that cannot move.
module depth_pixel_to_point (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dpp_pkg::dpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dpp_pkg::dpp_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import dpp_pkg::*;

  // Configuration registers
  logic [4:0]  stride_r;
  logic [31:0] depth_min_r;
  logic [31:0] depth_max_r;
  logic [19:0] center_col_r;
  logic [19:0] center_row_r;
  logic [24:0] recip_fx_r;
  logic [24:0] recip_fy_r;

  // Pipeline control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, out_v_nxt;
  logic s1_free, s2_free, s3_free, s4_free, out_free;
  dpp_stage_ld_t ld;

  // Stage payload
  logic [11:0] s1_col_r, s1_row_r;
  logic [11:0] s1_qc_r, s1_qr_r;
  logic [31:0] s1_depth_r, s2_depth_r, s3_depth_r, s4_depth_r;
  logic        s1_base_r, s1_last_r;
  logic        s2_keep_r, s3_keep_r, s4_keep_r;
  logic        s2_last_r, s3_last_r, s4_last_r;
  dpp_out_t    out_data_r, out_data_nxt;

  // Filter and stride logic
  logic [4:0]        stride_eff;
  logic [STR_RW-1:0] stride_rcp;
  logic [30:0]       prod_c, prod_r;
  logic              base_ok;
  logic              col_hit, row_hit, keep_s1;
  logic signed [31:0] coord_x, coord_y;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r     <= 5'd1;
      depth_min_r  <= DEPTH_MIN_RST;
      depth_max_r  <= DEPTH_MAX_RST;
      center_col_r <= '0;
      center_row_r <= '0;
      recip_fx_r   <= '0;
      recip_fy_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_STRIDE:  stride_r     <= cfg_data[4:0];
        CFG_DEPTH_MINIMUM: depth_min_r  <= cfg_data;
        CFG_DEPTH_MAXIMUM: depth_max_r  <= cfg_data;
        CFG_CENTER_COL:    center_col_r <= cfg_data[19:0];
        CFG_CENTER_ROW:    center_row_r <= cfg_data[19:0];
        CFG_RECIP_FOCAL_X: recip_fx_r   <= cfg_data[24:0];
        CFG_RECIP_FOCAL_Y: recip_fy_r   <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // Elastic pipeline: a stage frees when empty or when its item moves on
  always_comb begin
    out_free = !out_v_r || !out_stall;
    s4_free  = !s4_v_r || out_free;
    s3_free  = !s3_v_r || s4_free;
    s2_free  = !s2_v_r || s3_free;
    s1_free  = !s1_v_r || s2_free;
    ld.s1    = s1_free;
    ld.s2    = s2_free;
    ld.s3    = s3_free;
    ld.s4    = s4_free;
    in_stall = !s1_free;
  end

  // Stage 1 filters: pixel range, finite depth, depth window, intrinsics set
  always_comb begin
    stride_eff = (stride_r == '0) ? 5'd1 : stride_r;
    stride_rcp = STRIDE_RECIP[stride_r];
    prod_c     = 31'(in_data.pixel_col) * 31'(stride_rcp);
    prod_r     = 31'(in_data.pixel_row) * 31'(stride_rcp);
    base_ok    = (32'(in_data.pixel_col) < 32'(MAX_DIM))
              && (32'(in_data.pixel_row) < 32'(MAX_DIM))
              && in_data.depth_finite
              && (in_data.depth_value >= depth_min_r)
              && (in_data.depth_value <= depth_max_r)
              && (recip_fx_r != '0) && (recip_fy_r != '0);
  end

  // Stage 2 stride check: quotient times stride must give the pixel back
  always_comb begin
    col_hit = (17'(s1_qc_r) * 17'(stride_eff)) == 17'(s1_col_r);
    row_hit = (17'(s1_qr_r) * 17'(stride_eff)) == 17'(s1_row_r);
    keep_s1 = s1_base_r && col_hit && row_hit;
  end

  // Valid bits; an item with no result leaves the pipe at stage 2
  always_comb begin
    s1_v_nxt  = s1_free ? in_valid : s1_v_r;
    s2_v_nxt  = s2_free ? (s1_v_r && (keep_s1 || s1_last_r)) : s2_v_r;
    s3_v_nxt  = s3_free ? s2_v_r : s3_v_r;
    s4_v_nxt  = s4_free ? s3_v_r : s4_v_r;
    out_v_nxt = out_free ? s4_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      s4_v_r  <= s4_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload side of the stages
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      s1_col_r   <= in_data.pixel_col;
      s1_row_r   <= in_data.pixel_row;
      s1_qc_r    <= prod_c[29:18];
      s1_qr_r    <= prod_r[29:18];
      s1_depth_r <= in_data.depth_value;
      s1_base_r  <= base_ok;
      s1_last_r  <= in_data.frame_last;
    end
    if (ld.s2) begin
      s2_depth_r <= s1_depth_r;
      s2_keep_r  <= keep_s1;
      s2_last_r  <= s1_last_r;
    end
    if (ld.s3) begin
      s3_depth_r <= s2_depth_r;
      s3_keep_r  <= s2_keep_r;
      s3_last_r  <= s2_last_r;
    end
    if (ld.s4) begin
      s4_depth_r <= s3_depth_r;
      s4_keep_r  <= s3_keep_r;
      s4_last_r  <= s3_last_r;
    end
    if (out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Projection datapaths, one per axis
  dpp_axis u_axis_x (
    .clk      (clk),
    .ld       (ld),
    .pix      (in_data.pixel_col),
    .center   (center_col_r),
    .depth_s1 (s1_depth_r),
    .recip    (recip_fx_r),
    .coord    (coord_x)
  );

  dpp_axis u_axis_y (
    .clk      (clk),
    .ld       (ld),
    .pix      (in_data.pixel_row),
    .center   (center_row_r),
    .depth_s1 (s1_depth_r),
    .recip    (recip_fy_r),
    .coord    (coord_y)
  );

  // Result: a point, or a bare frame marker for a dropped last pixel
  always_comb begin
    if (s4_keep_r) begin
      out_data_nxt.point_x     = coord_x;
      out_data_nxt.point_y     = coord_y;
      out_data_nxt.point_z     = s4_depth_r;
      out_data_nxt.point_valid = 1'b1;
      out_data_nxt.frame_end   = s4_last_r;
    end else begin
      out_data_nxt.point_x     = '0;
      out_data_nxt.point_y     = '0;
      out_data_nxt.point_z     = '0;
      out_data_nxt.point_valid = 1'b0;
      out_data_nxt.frame_end   = 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // A bare marker always closes a frame and carries zero coordinates
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_data_r.point_valid |->
      out_data_r.frame_end && out_data_r.point_x == '0 &&
      out_data_r.point_y == '0 && out_data_r.point_z == '0)
    else $error("frame marker with nonzero payload");

  // A new result only comes from an item that sat in the last stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s4_v_r))
    else $error("result appeared without an item in stage 4");

  // Back-pressure only when every stage and the output register hold an item
  a_stall_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_v_r)
    else $error("input stalled with a free stage");

endmodule
